@@ hw/rtl/apw_pkg.sv @@
// apw_pkg: shared types and constants of the adaptive poll window block
// fsm state encoding, register indexes, action codes, command/status structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package apw_pkg;

    // field widths fixed by the item format
    localparam int unsigned WIN_W   = 32;
    localparam int unsigned CPU_W   = 3;
    localparam int unsigned FACT_W  = 8;
    localparam int unsigned PROD_W  = WIN_W + FACT_W;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CNT_W   = 5;

    // register reset values
    localparam logic [WIN_W-1:0]  RST_MAX_POLL   = 32'd200000;
    localparam logic [WIN_W-1:0]  RST_GROW_FLOOR = 32'd10000;
    localparam logic [FACT_W-1:0] RST_GROW_FACT  = 8'd2;
    localparam logic [FACT_W-1:0] RST_SHRINK_DIV = 8'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POLL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_FACT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_DIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_EN  = 3'd4;

    // result action codes
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GROWN  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SHRUNK = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RSVD   = 2'd3;

    // last step of the bit-serial divide
    localparam logic [CNT_W-1:0] DIV_LAST = 5'd31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_GROW,
        S_DIV,
        S_SHRINK,
        S_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request and read table
        logic take_win;   // latch current window
        logic mul;        // register window * grow factor
        logic grow_set;   // clamp product into window
        logic zero_set;   // shrink with zero divisor
        logic div_init;   // start serial divide
        logic div_step;   // one quotient bit
        logic shrink_set; // take quotient as window
        logic commit;     // write back and load result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic grow;
        logic shrink;
        logic div_zero;
        logic div_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hw/rtl/apw_ctrl.sv @@
// apw_ctrl: sequencing state machine of the adaptive poll window block
// issues datapath commands and handles the request-side handshake
// depends on apw_pkg
`timescale 1ns / 1ps
`default_nettype none

module apw_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire apw_pkg::t_dp_stat i_stat,
    output apw_pkg::t_dp_cmd  o_cmd
);

    apw_pkg::t_state r_state;
    apw_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            apw_pkg::S_IDLE: begin
                if (i_in_valid) n_state = apw_pkg::S_READ;
            end
            apw_pkg::S_READ: begin
                n_state = apw_pkg::S_DECIDE;
            end
            apw_pkg::S_DECIDE: begin
                if (i_stat.grow) begin
                    n_state = apw_pkg::S_GROW;
                end else if (i_stat.shrink && !i_stat.div_zero) begin
                    n_state = apw_pkg::S_DIV;
                end else begin
                    n_state = apw_pkg::S_COMMIT;
                end
            end
            apw_pkg::S_GROW: begin
                n_state = apw_pkg::S_COMMIT;
            end
            apw_pkg::S_DIV: begin
                if (i_stat.div_last) n_state = apw_pkg::S_SHRINK;
            end
            apw_pkg::S_SHRINK: begin
                n_state = apw_pkg::S_COMMIT;
            end
            apw_pkg::S_COMMIT: begin
                if (i_stat.out_free) n_state = apw_pkg::S_IDLE;
            end
            default: begin
                n_state = apw_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            apw_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            apw_pkg::S_READ: begin
                o_cmd.take_win = 1'b1;
            end
            apw_pkg::S_DECIDE: begin
                if (i_stat.grow) begin
                    o_cmd.mul = 1'b1;
                end else if (i_stat.shrink) begin
                    o_cmd.zero_set = i_stat.div_zero;
                    o_cmd.div_init = !i_stat.div_zero;
                end
            end
            apw_pkg::S_GROW: begin
                o_cmd.grow_set = 1'b1;
            end
            apw_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            apw_pkg::S_SHRINK: begin
                o_cmd.shrink_set = 1'b1;
            end
            apw_pkg::S_COMMIT: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // only one request in flight: a new one is never loaded mid-item
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == apw_pkg::S_READ))
        else $error("load outside idle");

    // divide runs only after a nonzero-divisor shrink decision
    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == apw_pkg::S_DIV) && ($past(r_state) == apw_pkg::S_DECIDE)
            |-> $past(i_stat.shrink) && !$past(i_stat.div_zero) && !$past(i_stat.grow))
        else $error("divide entered without shrink decision");

    // commit leaves for idle in the same step
    a_commit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == apw_pkg::S_IDLE))
        else $error("commit did not return to idle");

endmodule

`default_nettype wire

@@ hw/rtl/apw_dp.sv @@
// apw_dp: datapath of the adaptive poll window block
// config registers, window table, grow multiply and clamp, serial divider
// depends on apw_pkg
`timescale 1ns / 1ps
`default_nettype none

module apw_dp #(
    parameter int unsigned NUM_CPUS = 8
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration writes
    input  wire                                i_cfg_we,
    input  wire  [apw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [apw_pkg::WIN_W-1:0]          i_cfg_wdata,
    // request fields
    input  wire                                i_req_type,
    input  wire  [apw_pkg::CPU_W-1:0]          i_cpu_index,
    input  wire  [apw_pkg::WIN_W-1:0]          i_block_time_ns,
    // result
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [apw_pkg::WIN_W-1:0]          o_window_ns,
    output logic [apw_pkg::ACT_W-1:0]          o_action,
    // control
    input  wire apw_pkg::t_dp_cmd              i_cmd,
    output apw_pkg::t_dp_stat                  o_stat
);

    localparam int unsigned IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int unsigned EXT_W = 9;

    // configuration registers
    logic [apw_pkg::WIN_W-1:0]  r_max_poll;
    logic [apw_pkg::FACT_W-1:0] r_grow_fact;
    logic [apw_pkg::FACT_W-1:0] r_shrink_div;
    logic [apw_pkg::WIN_W-1:0]  r_grow_floor;
    logic                       r_shrink_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_poll   <= apw_pkg::RST_MAX_POLL;
            r_grow_fact  <= apw_pkg::RST_GROW_FACT;
            r_shrink_div <= apw_pkg::RST_SHRINK_DIV;
            r_grow_floor <= apw_pkg::RST_GROW_FLOOR;
            r_shrink_en  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                apw_pkg::CFG_MAX_POLL:   r_max_poll   <= i_cfg_wdata;
                apw_pkg::CFG_GROW_FACT:  r_grow_fact  <= i_cfg_wdata[apw_pkg::FACT_W-1:0];
                apw_pkg::CFG_SHRINK_DIV: r_shrink_div <= i_cfg_wdata[apw_pkg::FACT_W-1:0];
                apw_pkg::CFG_GROW_FLOOR: r_grow_floor <= i_cfg_wdata;
                apw_pkg::CFG_SHRINK_EN:  r_shrink_en  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // cpu index decode
    logic [EXT_W-1:0] cpu_ext;
    logic             cpu_oor;
    logic [IDX_W-1:0] cpu_idx;

    assign cpu_ext = {{(EXT_W - apw_pkg::CPU_W){1'b0}}, i_cpu_index};
    assign cpu_oor = cpu_ext >= EXT_W'(NUM_CPUS);
    assign cpu_idx = cpu_ext[IDX_W-1:0];

    // window table with per-entry valid bits
    logic [apw_pkg::WIN_W-1:0] r_mem [NUM_CPUS];
    logic [NUM_CPUS-1:0]       r_valid;
    logic [apw_pkg::WIN_W-1:0] r_rd_data;
    logic                      r_rd_vld;

    // request capture
    logic                      r_req;
    logic                      r_oor;
    logic [IDX_W-1:0]          r_idx;
    logic [apw_pkg::WIN_W-1:0] r_block;

    // working registers
    logic [apw_pkg::WIN_W-1:0]  r_win;
    logic [apw_pkg::ACT_W-1:0]  r_act;
    logic [apw_pkg::PROD_W-1:0] r_prod;
    logic [apw_pkg::WIN_W-1:0]  r_quo;
    logic [apw_pkg::FACT_W-1:0] r_rem;
    logic [apw_pkg::CNT_W-1:0]  r_cnt;

    // result register
    logic                      r_ovalid;
    logic [apw_pkg::WIN_W-1:0] r_owin;
    logic [apw_pkg::ACT_W-1:0] r_oact;

    logic write_en;
    assign write_en = i_cmd.commit && r_req && !r_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (write_en) begin
            r_valid[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (write_en) begin
            r_mem[r_idx] <= r_win;
        end
        if (i_cmd.load) begin
            r_rd_data <= r_mem[cpu_idx];
            r_rd_vld  <= r_valid[cpu_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_oor   <= cpu_oor;
            r_idx   <= cpu_idx;
            r_block <= i_block_time_ns;
        end
    end

    // grow clamp: floor first, then cap
    logic [apw_pkg::PROD_W-1:0] floor_ext;
    logic [apw_pkg::PROD_W-1:0] max_ext;
    logic [apw_pkg::PROD_W-1:0] prod_fl;
    logic [apw_pkg::WIN_W-1:0]  grow_val;

    assign floor_ext = {{apw_pkg::FACT_W{1'b0}}, r_grow_floor};
    assign max_ext   = {{apw_pkg::FACT_W{1'b0}}, r_max_poll};
    assign prod_fl   = (r_prod < floor_ext) ? floor_ext : r_prod;
    assign grow_val  = (prod_fl > max_ext) ? r_max_poll : prod_fl[apw_pkg::WIN_W-1:0];

    // restoring divide step, one quotient bit
    logic [apw_pkg::FACT_W:0]   rem_sh;
    logic                       rem_ge;
    logic [apw_pkg::FACT_W:0]   rem_nx;

    assign rem_sh = {r_rem, r_quo[apw_pkg::WIN_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_shrink_div};
    assign rem_nx = rem_ge ? (rem_sh - {1'b0, r_shrink_div}) : rem_sh;

    // window and action updates
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_win) begin
            r_win <= (r_oor || !r_rd_vld) ? '0 : r_rd_data;
            r_act <= apw_pkg::ACT_NONE;
        end
        if (i_cmd.mul) begin
            r_prod <= apw_pkg::PROD_W'(r_win) * apw_pkg::PROD_W'(r_grow_fact);
        end
        if (i_cmd.grow_set) begin
            r_win <= grow_val;
            r_act <= apw_pkg::ACT_GROWN;
        end
        if (i_cmd.zero_set) begin
            r_win <= '0;
            r_act <= apw_pkg::ACT_SHRUNK;
        end
        if (i_cmd.div_init) begin
            r_quo <= r_win;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[apw_pkg::WIN_W-2:0], rem_ge};
            r_rem <= rem_nx[apw_pkg::FACT_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.shrink_set) begin
            r_win <= r_quo;
            r_act <= apw_pkg::ACT_SHRUNK;
        end
    end

    // result register, held until taken
    logic out_free;
    assign out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_owin <= r_win;
            r_oact <= r_act;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_window_ns = r_owin;
    assign o_action    = r_oact;

    // status to controller
    logic active;
    assign active = r_req && !r_oor;

    assign o_stat.grow     = active && (r_block > r_win) && (r_block <= r_max_poll);
    assign o_stat.shrink   = active && (r_block > r_max_poll) && r_shrink_en;
    assign o_stat.div_zero = (r_shrink_div == '0);
    assign o_stat.div_last = (r_cnt == apw_pkg::DIV_LAST);
    assign o_stat.out_free = out_free;

    // remainder stays below the divisor throughout the divide
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_shrink_div))
        else $error("divider remainder out of range");

    // a grown window never exceeds the maximum
    a_grow_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && (r_oact == apw_pkg::ACT_GROWN) |-> (r_owin <= r_max_poll))
        else $error("grown window above maximum");

    // reserved action code never shows up
    a_act_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_oact != apw_pkg::ACT_RSVD))
        else $error("reserved action code");

    // a commit never overwrites a result that was not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_ovalid || i_out_ready))
        else $error("result overwritten");

endmodule

`default_nettype wire

@@ hw/rtl/adaptive_poll_window_core.sv @@
// sequence: accept, table read, decide, then commit for a query, zero-divisor
// shrink or no change; a grow adds a clamp state, a nonzero-divisor shrink the
// 32-step divider and a shrink state; one request in flight, the next is taken
// once the previous result is in the output register; commit waits for it to free
// reset: synchronous active low; clears table valid bits, loads register
// defaults, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module adaptive_poll_window_core #(
    parameter int unsigned NUM_CPUS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration port
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_wdata,
    // request stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,  // cpu_index[2:0], block_time_ns[34:3], zero pad
    input  wire  [0:0]  s_axis_tuser,  // req_type[0]
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,  // window_ns[31:0]
    output logic [1:0]  m_axis_tuser   // action[1:0]
);

    apw_pkg::t_dp_cmd  cmd;
    apw_pkg::t_dp_stat stat;

    // sequencer
    apw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    apw_dp #(
        .NUM_CPUS (NUM_CPUS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_type      (s_axis_tuser[0]),
        .i_cpu_index     (s_axis_tdata[2:0]),
        .i_block_time_ns (s_axis_tdata[34:3]),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_window_ns     (m_axis_tdata),
        .o_action        (m_axis_tuser),
        .i_cmd           (cmd),
        .o_stat          (stat)
    );

endmodule

`default_nettype wire
